>>> design/rlf_pkg.sv
// shared types, widths and codes for the rgb linear fade controller
`timescale 1ns / 1ps

package rlf_pkg;

    // field and state widths
    localparam int LEVEL_W   = 8;
    localparam int REQ_W     = 16;
    localparam int CNT_W     = 16;
    localparam int NUM_CH    = 3;
    localparam int CH_W      = 2;
    localparam int CFG_IDX_W = 2;

    // step times |start - target| needs a 16 x 8 bit product
    localparam int PROD_W    = CNT_W + LEVEL_W;

    // divider retires two quotient bits per iteration
    localparam int DIV_BITS  = 2;
    localparam int DIV_ITERS = PROD_W / DIV_BITS;
    localparam int LOOP_W    = $clog2(DIV_ITERS);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    // register reset values
    localparam logic [CNT_W-1:0] STEP_INTERVAL_RST = 16'd100;
    localparam logic [CNT_W-1:0] TOTAL_STEPS_RST   = 16'd500;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_STEPS   = 2'd1;

    // item opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_FADE = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [REQ_W-1:0] red;
        logic [REQ_W-1:0] green;
        logic [REQ_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_duty;
        logic [LEVEL_W-1:0] green_duty;
        logic [LEVEL_W-1:0] blue_duty;
        logic               red_enable;
        logic               green_enable;
        logic               blue_enable;
        logic               fading;
    } t_out_item;

    // divider controls from the sequencer
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

>>> design/rlf_div.sv
// serial restoring divider, two quotient bits per cycle while step is set
`timescale 1ns / 1ps

module rlf_div
    import rlf_pkg::*;
(
    input  logic              i_clk,
    input  t_div_ctl          i_ctl,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic [PROD_W-1:0] o_quotient,
    output logic              o_rem_nz
);

    logic [PROD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [PROD_W-1:0] n_quo;
    logic [CNT_W-1:0]  n_rem;

    logic [CNT_W:0]    rem_a;
    logic [CNT_W:0]    rem_a_sub;
    logic              ge_a;
    logic [PROD_W-1:0] quo_a;
    logic [CNT_W:0]    rem_b;
    logic [CNT_W:0]    rem_b_sub;
    logic              ge_b;

    // two shift and subtract steps; remainder stays below the divisor
    always_comb begin
        rem_a     = {r_rem, r_quo[PROD_W-1]};
        ge_a      = rem_a >= {1'b0, i_divisor};
        rem_a_sub = ge_a ? rem_a - {1'b0, i_divisor} : rem_a;
        quo_a     = {r_quo[PROD_W-2:0], ge_a};

        rem_b     = {rem_a_sub[CNT_W-1:0], quo_a[PROD_W-1]};
        ge_b      = rem_b >= {1'b0, i_divisor};
        rem_b_sub = ge_b ? rem_b - {1'b0, i_divisor} : rem_b;

        n_quo     = {quo_a[PROD_W-2:0], ge_b};
        n_rem     = rem_b_sub[CNT_W-1:0];
    end

    // load the dividend or run one iteration
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_rem_nz   = r_rem != '0;

endmodule

>>> design/rgb_linear_fade_controller.sv
// top level: microcoded sequencer and datapath of the rgb linear fade controller
`timescale 1ns / 1ps

// Three-channel LED colour controller with a linear fade. Items carry an
// opcode (tick, set, fade) and three requested levels that are clamped to
// 255; each item returns one result with the three duty values, their
// enable bits and the fading flag. Control is a small microprogram in a
// read-only table stepped by a program counter. The unused opcode goes
// from acceptance straight to the emit step; set and fade items and ticks
// that take no fade step pass through their own step first. A tick that
// takes a fade step runs a 16 x 8 multiply and a 12-iteration serial divide
// for each channel in turn, on one divider that the channels share. One item
// is in work at a time; the next item is accepted in the cycle after the
// result is loaded into the output register, even while that result is
// still stalled.

module rgb_linear_fade_controller
    import rlf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        U_FETCH,
        U_TICK,
        U_MUL,
        U_DINIT,
        U_DSTEP,
        U_WRCH,
        U_FIN,
        U_EMIT,
        U_SET,
        U_FADE
    } t_uop;

    typedef struct packed {
        t_uop            uop;
        logic [PC_W-1:0] target;
    } t_cword;

    // microprogram addresses
    localparam logic [PC_W-1:0] A_FETCH = 4'd0;
    localparam logic [PC_W-1:0] A_TICK  = 4'd1;
    localparam logic [PC_W-1:0] A_MUL   = 4'd2;
    localparam logic [PC_W-1:0] A_DINIT = 4'd3;
    localparam logic [PC_W-1:0] A_DSTEP = 4'd4;
    localparam logic [PC_W-1:0] A_WRCH  = 4'd5;
    localparam logic [PC_W-1:0] A_FIN   = 4'd6;
    localparam logic [PC_W-1:0] A_EMIT  = 4'd7;
    localparam logic [PC_W-1:0] A_SET   = 4'd8;
    localparam logic [PC_W-1:0] A_FADE  = 4'd9;

    localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(NUM_CH - 1);
    localparam logic [LOOP_W-1:0] LOOP_LAST = LOOP_W'(DIV_ITERS - 1);

    // control store: one word per step, target is the jump address
    function automatic t_cword f_rom(input logic [PC_W-1:0] addr);
        t_cword w;
        unique case (addr)
            A_FETCH: w = '{uop: U_FETCH, target: A_FETCH};
            A_TICK:  w = '{uop: U_TICK,  target: A_EMIT};
            A_MUL:   w = '{uop: U_MUL,   target: A_DINIT};
            A_DINIT: w = '{uop: U_DINIT, target: A_DSTEP};
            A_DSTEP: w = '{uop: U_DSTEP, target: A_WRCH};
            A_WRCH:  w = '{uop: U_WRCH,  target: A_MUL};
            A_FIN:   w = '{uop: U_FIN,   target: A_EMIT};
            A_EMIT:  w = '{uop: U_EMIT,  target: A_FETCH};
            A_SET:   w = '{uop: U_SET,   target: A_EMIT};
            A_FADE:  w = '{uop: U_FADE,  target: A_EMIT};
            default: w = '{uop: U_FETCH, target: A_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic [LEVEL_W-1:0] f_clamp(input logic [REQ_W-1:0] v);
        return (v > REQ_W'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
    endfunction

    // sequencer and state registers
    logic [PC_W-1:0]    r_pc;
    logic [CH_W-1:0]    r_ch;
    logic [LOOP_W-1:0]  r_loop;
    logic [CNT_W-1:0]   r_interval;
    logic [CNT_W-1:0]   r_total;
    logic [LEVEL_W-1:0] r_cur    [NUM_CH];
    logic [LEVEL_W-1:0] r_start  [NUM_CH];
    logic [LEVEL_W-1:0] r_target [NUM_CH];
    logic [LEVEL_W-1:0] r_req    [NUM_CH];
    logic               r_fade;
    logic [CNT_W-1:0]   r_step;
    logic [CNT_W-1:0]   r_elapsed;
    logic [PROD_W-1:0]  r_prod;
    logic [LEVEL_W-1:0] r_s;
    logic               r_neg;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [PC_W-1:0]    n_pc;
    t_cword             cword;
    logic               in_accept;
    logic               out_free;
    logic [CNT_W-1:0]   elapsed_inc;
    logic               take_step;
    logic [CNT_W-1:0]   n_div;
    logic [LEVEL_W-1:0] sel_s;
    logic [LEVEL_W-1:0] sel_t;
    logic [LEVEL_W-1:0] mag;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  quo;
    logic               rem_nz;
    logic [PROD_W:0]    ceil_q;
    logic [PROD_W:0]    up_sum;
    logic [LEVEL_W-1:0] ch_level;
    t_div_ctl           div_ctl;

    assign cword     = f_rom(r_pc);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // tick bookkeeping
    assign elapsed_inc = (r_elapsed != CNT_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign take_step   = r_fade && (elapsed_inc >= r_interval);
    assign n_div       = (r_total == '0) ? CNT_W'(1) : r_total;

    // channel magnitude and product of step count and distance
    assign sel_s = r_start[r_ch];
    assign sel_t = r_target[r_ch];
    assign mag   = (sel_s >= sel_t) ? sel_s - sel_t : sel_t - sel_s;
    assign prod  = PROD_W'(r_step) * PROD_W'(mag);

    // new level: down uses a ceiling quotient, up a floor, both saturated
    always_comb begin
        ceil_q = {1'b0, quo} + (PROD_W + 1)'(rem_nz);
        up_sum = {1'b0, quo} + (PROD_W + 1)'(r_s);
        if (!r_neg) begin
            ch_level = (ceil_q > (PROD_W + 1)'(r_s)) ? '0 : r_s - ceil_q[LEVEL_W-1:0];
        end else begin
            ch_level = (up_sum > (PROD_W + 1)'(LEVEL_MAX)) ? LEVEL_MAX
                                                           : up_sum[LEVEL_W-1:0];
        end
    end

    // divider controls
    always_comb begin
        div_ctl.load = cword.uop == U_DINIT;
        div_ctl.step = cword.uop == U_DSTEP;
    end

    rlf_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (r_prod),
        .i_divisor  (n_div),
        .o_quotient (quo),
        .o_rem_nz   (rem_nz)
    );

    // next program address
    always_comb begin
        n_pc = r_pc;
        unique case (cword.uop)
            U_FETCH: begin
                if (in_accept) begin
                    case (i_in_data.op)
                        OP_TICK: n_pc = A_TICK;
                        OP_SET:  n_pc = A_SET;
                        OP_FADE: n_pc = A_FADE;
                        default: n_pc = A_EMIT;
                    endcase
                end
            end
            U_TICK:  n_pc = take_step ? r_pc + 1'b1 : cword.target;
            U_MUL:   n_pc = cword.target;
            U_DINIT: n_pc = cword.target;
            U_DSTEP: n_pc = (r_loop == LOOP_LAST) ? cword.target : r_pc;
            U_WRCH:  n_pc = (r_ch == CH_LAST) ? r_pc + 1'b1 : cword.target;
            U_FIN:   n_pc = cword.target;
            U_EMIT:  n_pc = out_free ? cword.target : r_pc;
            U_SET:   n_pc = cword.target;
            U_FADE:  n_pc = cword.target;
            default: n_pc = A_FETCH;
        endcase
    end

    // sequencer state, datapath registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= A_FETCH;
            r_ch        <= '0;
            r_loop      <= '0;
            r_interval  <= STEP_INTERVAL_RST;
            r_total     <= TOTAL_STEPS_RST;
            r_fade      <= 1'b0;
            r_step      <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_cur[i]    <= '0;
                r_start[i]  <= '0;
                r_target[i] <= '0;
            end
        end else begin
            r_pc <= n_pc;

            // register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STEP_INTERVAL: r_interval <= i_cfg_data;
                    CFG_TOTAL_STEPS:   r_total    <= i_cfg_data;
                    default: ;
                endcase
            end

            // result register: loaded by the emit step, cleared once taken
            if (cword.uop == U_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (cword.uop)
                U_FETCH: begin
                    if (in_accept) begin
                        r_req[0] <= f_clamp(i_in_data.red);
                        r_req[1] <= f_clamp(i_in_data.green);
                        r_req[2] <= f_clamp(i_in_data.blue);
                    end
                end
                U_TICK: begin
                    if (take_step) begin
                        r_elapsed <= '0;
                        r_ch      <= '0;
                        if (r_step != CNT_MAX) begin
                            r_step <= r_step + 1'b1;
                        end
                    end else begin
                        r_elapsed <= elapsed_inc;
                    end
                end
                U_MUL: begin
                    r_prod <= prod;
                    r_s    <= sel_s;
                    r_neg  <= sel_s < sel_t;
                end
                U_DINIT: begin
                    r_loop <= '0;
                end
                U_DSTEP: begin
                    r_loop <= r_loop + 1'b1;
                end
                U_WRCH: begin
                    r_cur[r_ch] <= ch_level;
                    r_ch        <= r_ch + 1'b1;
                end
                U_FIN: begin
                    if (r_step >= n_div) begin
                        r_fade <= 1'b0;
                    end
                end
                U_EMIT: begin
                    if (out_free) begin
                        r_out.red_duty     <= r_cur[0];
                        r_out.green_duty   <= r_cur[1];
                        r_out.blue_duty    <= r_cur[2];
                        r_out.red_enable   <= r_cur[0] != '0;
                        r_out.green_enable <= r_cur[1] != '0;
                        r_out.blue_enable  <= r_cur[2] != '0;
                        r_out.fading       <= r_fade;
                    end
                end
                U_SET: begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        r_cur[i] <= r_req[i];
                    end
                    r_fade <= 1'b0;
                end
                U_FADE: begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        r_start[i]  <= r_cur[i];
                        r_target[i] <= r_req[i];
                    end
                    r_fade <= 1'b1;
                    r_step <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall  = cword.uop != U_FETCH;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // a new result only appears from the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cword.uop) == U_EMIT)
        else $error("result raised outside the emit step");

    // the divide loop never runs past its iteration count
    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cword.uop == U_DSTEP) |-> (r_loop <= LOOP_LAST))
        else $error("divider loop overran");

    // a set item always cancels a running fade
    a_set_cancels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cword.uop == U_SET) |=> !r_fade)
        else $error("fade still running after set");

    // channel pointer stays within the channels whenever a level is written
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cword.uop == U_WRCH) |-> (r_ch <= CH_LAST))
        else $error("channel index out of range");
`endif

endmodule
